[rtl/core/bpb_pkg.sv]
// Shared types and constants of the branch predictor with target buffer.
`default_nettype none
package bpb_pkg;

	localparam int PC_W           = 32;
	localparam int TAG_W          = 21;
	localparam int CNT_W          = 32;
	localparam int MODE_W         = 2;
	localparam int STATE_W        = 2;
	localparam int IDX_MAX_W      = 16;
	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int QUEUE_DEPTH    = 2;

	// predictor modes
	localparam logic [MODE_W-1:0] MODE_TAKEN     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NOT_TAKEN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ONE_BIT   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_COUNTER   = 2'd3;

	// predictor state codes
	localparam logic [STATE_W-1:0] CTR_MIN  = 2'd0;
	localparam logic [STATE_W-1:0] CTR_NEW  = 2'd1;
	localparam logic [STATE_W-1:0] CTR_WEAK = 2'd2;
	localparam logic [STATE_W-1:0] CTR_MAX  = 2'd3;

	typedef struct packed {
		logic [IDX_MAX_W-1:0] idx;
		logic [TAG_W-1:0]     tag;
		logic                 taken;
		logic [PC_W-1:0]      target;
	} bpb_item_t;

	typedef struct packed {
		logic clearing;
		logic active;
	} bpb_back_stat_t;

endpackage : bpb_pkg
`default_nettype wire

[rtl/core/bpb_front.sv]
// Front end: takes a branch beat, decides the outcome and splits the address.
`default_nettype none
module bpb_front #(
	parameter int TABLE_ENTRIES = bpb_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [bpb_pkg::PC_W-1:0] branch_pc,
	input  wire logic [bpb_pkg::PC_W-1:0] following_pc,
	input  wire logic                    q_full,
	output logic                         push,
	output bpb_pkg::bpb_item_t           push_item,
	output logic                         active
);
	import bpb_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int SHIFT = 31 + IDX_W;
	localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(TABLE_ENTRIES);
	localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
	localparam logic [30:0] ENTRIES_W = 31'(TABLE_ENTRIES);

	logic            valid_s1, valid_s2, valid_s3;
	logic [30:0]     half_s1, half_s2, half_s3;
	logic [PC_W-1:0] nxt_s1, nxt_s2, nxt_s3;
	logic            taken_s1, taken_s2, taken_s3;
	logic [62:0]     prod_s2;
	logic [30:0]     qe_s3, qn_s3;
	logic [30:0]     qe_c, rem_c, quo_c, idx_c;
	logic            fix_c;
	logic            advance;

	assign advance = !(valid_s3 && q_full);
	assign push    = valid_s3 && !q_full;
	assign active  = valid_s1 || valid_s2 || valid_s3;

	// quotient estimate from the reciprocal is low by at most one
	assign qe_c  = 31'(prod_s2 >> SHIFT);
	assign rem_c = half_s3 - qn_s3;
	assign fix_c = rem_c >= ENTRIES_W;
	assign quo_c = qe_s3 + 31'(fix_c);
	assign idx_c = fix_c ? rem_c - ENTRIES_W : rem_c;

	always_comb begin
		push_item        = '0;
		push_item.idx    = IDX_MAX_W'(idx_c[IDX_W-1:0]);
		push_item.tag    = quo_c[TAG_W-1:0];
		push_item.taken  = taken_s3;
		push_item.target = nxt_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			half_s1  <= branch_pc[PC_W-1:1];
			nxt_s1   <= following_pc;
			taken_s1 <= following_pc != (branch_pc + PC_W'(4));
		end
		if (advance) begin
			half_s2  <= half_s1;
			nxt_s2   <= nxt_s1;
			taken_s2 <= taken_s1;
			prod_s2  <= 63'(half_s1) * 63'(RECIP);
			half_s3  <= half_s2;
			nxt_s3   <= nxt_s2;
			taken_s3 <= taken_s2;
			qe_s3    <= qe_c;
			qn_s3    <= 31'(qe_c * ENTRIES_W);
		end
	end

endmodule : bpb_front
`default_nettype wire

[rtl/core/bpb_queue.sv]
// Two-entry queue between the front end and the table back end.
`default_nettype none
module bpb_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire bpb_pkg::bpb_item_t push_item,
	input  wire logic               pop,
	output bpb_pkg::bpb_item_t      pop_item,
	output logic                    full,
	output logic                    empty
);
	import bpb_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	bpb_item_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule : bpb_queue
`default_nettype wire

[rtl/core/bpb_back.sv]
// Back end: table lookup, prediction, entry update and running counts.
`default_nettype none
module bpb_back #(
	parameter int TABLE_ENTRIES = bpb_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [bpb_pkg::MODE_W-1:0] mode,
	input  wire logic                       q_empty,
	input  wire bpb_pkg::bpb_item_t         q_item,
	output logic                            pop,
	output bpb_pkg::bpb_back_stat_t         stat,
	output logic                            done,
	output logic                            predicted_taken,
	output logic                            actual_taken,
	output logic                            prediction_right,
	output logic                            table_hit,
	output logic [bpb_pkg::PC_W-1:0]        stored_target,
	output logic [bpb_pkg::CNT_W-1:0]       right_count,
	output logic [bpb_pkg::CNT_W-1:0]       branch_count
);
	import bpb_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [PC_W-1:0]    target;
		logic [STATE_W-1:0] ctr;
	} entry_t;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_UPDATE} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] clr_idx_q;
	bpb_item_t        item_q;
	entry_t           rd_q;
	entry_t           mem [TABLE_ENTRIES];
	logic [CNT_W-1:0] right_total_q, branch_total_q;

	logic               mem_we;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic               hit, pred, right;
	logic [STATE_W-1:0] st_old, st_new;
	logic [PC_W-1:0]    old_target;
	logic [CNT_W-1:0]   right_next, branch_next;

	assign pop           = (state_q == ST_IDLE) && !q_empty;
	assign stat.clearing = state_q == ST_CLEAR;
	assign stat.active   = state_q != ST_IDLE;

	always_comb begin
		hit        = rd_q.valid && (rd_q.tag == item_q.tag);
		st_old     = hit ? rd_q.ctr : CTR_NEW;
		old_target = hit ? rd_q.target : '0;
		unique case (mode) inside
			MODE_TAKEN:                 pred = 1'b1;
			MODE_NOT_TAKEN:             pred = 1'b0;
			MODE_ONE_BIT, MODE_COUNTER: pred = st_old >= CTR_WEAK;
			default:                    pred = 1'b0;
		endcase
		right = pred == item_q.taken;
		if (mode == MODE_ONE_BIT) begin
			st_new = item_q.taken ? CTR_MAX : CTR_MIN;
		end else if (item_q.taken) begin
			st_new = (st_old == CTR_MAX) ? CTR_MAX : st_old + 1'b1;
		end else begin
			st_new = (st_old == CTR_MIN) ? CTR_MIN : st_old - 1'b1;
		end
		branch_next = (branch_total_q == '1) ? branch_total_q : branch_total_q + 1'b1;
		right_next  = (right && right_total_q != '1) ? right_total_q + 1'b1 : right_total_q;
	end

	// the clearing sweep and the entry update share the one write port
	always_comb begin
		mem_we  = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
		wr_addr = (state_q == ST_CLEAR) ? clr_idx_q : item_q.idx[IDX_W-1:0];
		wr_data = '0;
		if (state_q == ST_UPDATE) begin
			wr_data.valid  = 1'b1;
			wr_data.tag    = item_q.tag;
			wr_data.target = item_q.target;
			wr_data.ctr    = st_new;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (pop) begin
			rd_q   <= mem[q_item.idx[IDX_W-1:0]];
			item_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_idx_q      <= '0;
			done           <= 1'b0;
			right_total_q  <= '0;
			branch_total_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					done           <= 1'b1;
					right_total_q  <= right_next;
					branch_total_q <= branch_next;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			predicted_taken  <= pred;
			actual_taken     <= item_q.taken;
			prediction_right <= right;
			table_hit        <= hit;
			stored_target    <= old_target;
			right_count      <= right_next;
			branch_count     <= branch_next;
		end
	end

endmodule : bpb_back
`default_nettype wire

[rtl/core/branch_predictor_btb_unit.sv]
// Top level of the branch predictor with a direct-mapped branch target buffer.
`default_nettype none
// Each start beat carries one executed branch; its result appears on the result
// ports for one cycle with done high, once the beat has passed the front stages,
// the queue and the back end, and busy drops in that same cycle so the next
// branch can start. One branch is in flight at a time: three front stages split
// the address (reciprocal multiply and one correction) and the back end reads
// the single-port table memory in its idle state and writes the entry in its
// update state. After reset the table is swept clear with busy high. Results
// cannot be held off, so they must be taken in the cycle done is high. The mode
// register may be written at any time the block is idle.
module branch_predictor_btb_unit #(
	parameter int TABLE_ENTRIES = bpb_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [bpb_pkg::PC_W-1:0]   branch_pc,
	input  wire logic [bpb_pkg::PC_W-1:0]   following_pc,
	input  wire logic                       cfg_we,
	input  wire logic [bpb_pkg::MODE_W-1:0] cfg_wdata,
	output logic                            done,
	output logic                            predicted_taken,
	output logic                            actual_taken,
	output logic                            prediction_right,
	output logic                            table_hit,
	output logic [bpb_pkg::PC_W-1:0]        stored_target,
	output logic [bpb_pkg::CNT_W-1:0]       right_count,
	output logic [bpb_pkg::CNT_W-1:0]       branch_count
);
	import bpb_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              accept, push, pop, q_full, q_empty, front_active;
	bpb_item_t         push_item, pop_item;
	bpb_back_stat_t    back_stat;

	assign accept = start && !busy;
	assign busy   = front_active || !q_empty || back_stat.active || back_stat.clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COUNTER;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	bpb_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.branch_pc    (branch_pc),
		.following_pc (following_pc),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item),
		.active       (front_active)
	);

	bpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	bpb_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.mode             (mode_q),
		.q_empty          (q_empty),
		.q_item           (pop_item),
		.pop              (pop),
		.stat             (back_stat),
		.done             (done),
		.predicted_taken  (predicted_taken),
		.actual_taken     (actual_taken),
		.prediction_right (prediction_right),
		.table_hit        (table_hit),
		.stored_target    (stored_target),
		.right_count      (right_count),
		.branch_count     (branch_count)
	);

`ifndef ASSERT_OFF
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without work in flight");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after an accepted beat");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (branch_count != '0))
		else $error("branch count zero on a result beat");

	a_right_le_branch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (right_count <= branch_count))
		else $error("right count exceeds branch count");
`endif

endmodule : branch_predictor_btb_unit
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the branch predictor with target buffer.
`timescale 1ns / 1ps

module testbench;
	import bpb_pkg::*;

	localparam int ENTRIES = TABLE_ENTRIES_DEF;
	localparam logic [PC_W-1:0] SLOT_BITS = PC_W'((ENTRIES - 1) << 1);
	localparam int POOL = 24;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 113;

	typedef struct packed {
		logic             predicted_taken;
		logic             actual_taken;
		logic             prediction_right;
		logic             table_hit;
		logic [PC_W-1:0]  stored_target;
		logic [CNT_W-1:0] right_count;
		logic [CNT_W-1:0] branch_count;
	} branch_outcome_t;

	class btb_outcome_board;
		logic [MODE_W-1:0]  mode;
		bit                 slot_valid[ENTRIES];
		logic [TAG_W-1:0]   slot_tag[ENTRIES];
		logic [PC_W-1:0]    slot_target[ENTRIES];
		logic [STATE_W-1:0] slot_state[ENTRIES];
		logic [CNT_W-1:0]   right_total;
		logic [CNT_W-1:0]   branch_total;
		branch_outcome_t    outcome_q[$];
		int                 errors;
		int                 outcomes_seen;

		function new();
			mode = MODE_COUNTER;
			foreach (slot_valid[i])
				slot_valid[i] = 1'b0;
			right_total = '0;
			branch_total = '0;
			errors = 0;
			outcomes_seen = 0;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		// Predict and update one table entry for an accepted branch beat.
		function void predict_branch(logic [PC_W-1:0] pc, logic [PC_W-1:0] nxt);
			logic [PC_W-1:0]    half;
			int unsigned        slot;
			logic [TAG_W-1:0]   tag;
			logic [STATE_W-1:0] st;
			branch_outcome_t    want;
			half = pc >> 1;
			slot = half % ENTRIES;
			tag = TAG_W'(half / ENTRIES);
			want.table_hit = slot_valid[slot] && slot_tag[slot] == tag;
			st = want.table_hit ? slot_state[slot] : CTR_NEW;
			want.stored_target = want.table_hit ? slot_target[slot] : '0;
			want.actual_taken = nxt != pc + 32'd4;
			case (mode)
				MODE_TAKEN: want.predicted_taken = 1'b1;
				MODE_NOT_TAKEN: want.predicted_taken = 1'b0;
				default: want.predicted_taken = st >= CTR_WEAK;
			endcase
			want.prediction_right = want.predicted_taken == want.actual_taken;
			if (mode == MODE_ONE_BIT) begin
				st = want.actual_taken ? CTR_MAX : CTR_MIN;
			end else if (want.actual_taken) begin
				if (st != CTR_MAX)
					st = st + 1'b1;
			end else if (st != CTR_MIN) begin
				st = st - 1'b1;
			end
			slot_valid[slot] = 1'b1;
			slot_tag[slot] = tag;
			slot_target[slot] = nxt;
			slot_state[slot] = st;
			if (branch_total != '1)
				branch_total = branch_total + 1'b1;
			if (want.prediction_right && right_total != '1)
				right_total = right_total + 1'b1;
			want.right_count = right_total;
			want.branch_count = branch_total;
			outcome_q.insert(outcome_q.size(), want);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_outcome(branch_outcome_t got);
			branch_outcome_t want;
			if (outcome_q.size() == 0) begin
				report_mismatch("result strobe with no branch outstanding");
				return;
			end
			want = outcome_q.pop_front();
			outcomes_seen++;
			if (got.predicted_taken !== want.predicted_taken)
				report_mismatch($sformatf("beat %0d predicted_taken got %b want %b",
					outcomes_seen, got.predicted_taken, want.predicted_taken));
			if (got.actual_taken !== want.actual_taken)
				report_mismatch($sformatf("beat %0d actual_taken got %b want %b",
					outcomes_seen, got.actual_taken, want.actual_taken));
			if (got.prediction_right !== want.prediction_right)
				report_mismatch($sformatf("beat %0d prediction_right got %b want %b",
					outcomes_seen, got.prediction_right, want.prediction_right));
			if (got.table_hit !== want.table_hit)
				report_mismatch($sformatf("beat %0d table_hit got %b want %b",
					outcomes_seen, got.table_hit, want.table_hit));
			if (got.stored_target !== want.stored_target)
				report_mismatch($sformatf("beat %0d stored_target got %h want %h",
					outcomes_seen, got.stored_target, want.stored_target));
			if (got.right_count !== want.right_count)
				report_mismatch($sformatf("beat %0d right_count got %0d want %0d",
					outcomes_seen, got.right_count, want.right_count));
			if (got.branch_count !== want.branch_count)
				report_mismatch($sformatf("beat %0d branch_count got %0d want %0d",
					outcomes_seen, got.branch_count, want.branch_count));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [PC_W-1:0]   branch_pc;
	logic [PC_W-1:0]   following_pc;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;
	logic              done;
	logic              predicted_taken;
	logic              actual_taken;
	logic              prediction_right;
	logic              table_hit;
	logic [PC_W-1:0]   stored_target;
	logic [CNT_W-1:0]  right_count;
	logic [CNT_W-1:0]  branch_count;

	btb_outcome_board board;

	logic [PC_W-1:0] hot_pc[POOL];
	logic [PC_W-1:0] hot_target[POOL];
	int unsigned     hot_bias[POOL];

	branch_predictor_btb_unit #(
		.TABLE_ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.branch_pc(branch_pc),
		.following_pc(following_pc),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.predicted_taken(predicted_taken),
		.actual_taken(actual_taken),
		.prediction_right(prediction_right),
		.table_hit(table_hit),
		.stored_target(stored_target),
		.right_count(right_count),
		.branch_count(branch_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin : result_monitor
		branch_outcome_t seen;
		if (arst_n && done) begin
			seen.predicted_taken = predicted_taken;
			seen.actual_taken = actual_taken;
			seen.prediction_right = prediction_right;
			seen.table_hit = table_hit;
			seen.stored_target = stored_target;
			seen.right_count = right_count;
			seen.branch_count = branch_count;
			board.check_outcome(seen);
		end
	end

	// Hold start until the beat is taken, then note it.
	task automatic send_branch(input logic [PC_W-1:0] pc, input logic [PC_W-1:0] nxt);
		start <= 1'b1;
		branch_pc <= pc;
		following_pc <= nxt;
		do
			@(posedge clk);
		while (busy);
		board.predict_branch(pc, nxt);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		start <= 1'b0;
		while (board.pending() != 0 || busy)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.mode = m;
	endtask

	task automatic fill_pool();
		for (int i = 0; i < POOL; i++) begin
			hot_pc[i] = $urandom();
			// odd entries fight their neighbor for the same slot
			if (i % 2 == 1)
				hot_pc[i] = (hot_pc[i] & ~SLOT_BITS) | (hot_pc[i-1] & SLOT_BITS);
			hot_target[i] = ($urandom_range(0, 1) == 1) ? $urandom()
				: hot_pc[i] - PC_W'($urandom_range(4, 256));
			case ($urandom_range(0, 2))
				0: hot_bias[i] = 5;
				1: hot_bias[i] = 50;
				default: hot_bias[i] = 95;
			endcase
		end
	endtask

	task automatic run_random(input int count, input bit gaps_on);
		logic [PC_W-1:0] pc;
		logic [PC_W-1:0] nxt;
		int unsigned     kind;
		int unsigned     k;
		int unsigned     gap_pct;
		fill_pool();
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			k = $urandom_range(0, POOL - 1);
			if (kind < 60) begin
				pc = hot_pc[k];
				nxt = ($urandom_range(0, 99) < hot_bias[k]) ? hot_target[k] : pc + 32'd4;
				if ($urandom_range(0, 9) == 0)
					hot_target[k] = $urandom();
			end else if (kind < 72) begin
				// same entry through bit 0
				pc = hot_pc[k] ^ PC_W'($urandom_range(0, 1));
				nxt = ($urandom_range(0, 2) == 0) ? pc + 32'd4 : $urandom();
			end else if (kind < 88) begin
				pc = ($urandom() & ~SLOT_BITS) | (hot_pc[k] & SLOT_BITS);
				nxt = ($urandom_range(0, 1) == 1) ? pc + 32'd4 : $urandom();
			end else begin
				pc = $urandom();
				nxt = ($urandom_range(0, 1) == 1) ? pc + 32'd4 : $urandom();
			end
			send_branch(pc, nxt);
			gap_pct = ((i / 40) % 2 == 0) ? 30 : 0;
			if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 11))
					@(posedge clk);
			end
		end
	endtask

	initial begin
		logic [MODE_W-1:0] phase_mode[PHASES];
		phase_mode = '{MODE_ONE_BIT, MODE_COUNTER, MODE_TAKEN, MODE_NOT_TAKEN, MODE_COUNTER,
			MODE_ONE_BIT, MODE_NOT_TAKEN, MODE_TAKEN, MODE_ONE_BIT, MODE_COUNTER};
		board = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		branch_pc <= '0;
		following_pc <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		// wait out the table sweep
		do
			@(posedge clk);
		while (busy);

		// counter mode from reset: miss, saturation both ways, aliasing, eviction, wrap
		send_branch(32'h0000_0000, 32'h0000_0004);
		send_branch(32'h0000_0000, 32'h0000_0004);
		send_branch(32'h0000_0000, 32'h0000_0100);
		send_branch(32'h0000_0000, 32'h0000_0100);
		send_branch(32'h0000_0000, 32'h0000_0100);
		send_branch(32'h0000_0000, 32'h0000_0100);
		send_branch(32'h0000_0001, 32'h0000_0100);
		send_branch(32'h0000_0800, 32'h0000_0804);
		send_branch(32'h0000_0000, 32'h0000_0004);
		send_branch(32'hFFFF_FFFC, 32'h0000_0000);
		send_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_branch(32'hFFFF_FFFE, 32'h0000_0002);
		send_branch(32'hAAAA_AAAA, 32'h5555_5555);
		send_branch(32'h5555_5555, 32'hAAAA_AAAA);

		set_mode(MODE_ONE_BIT);
		send_branch(32'h0000_0040, 32'h0000_0080);
		send_branch(32'h0000_0040, 32'h0000_0080);
		send_branch(32'h0000_0040, 32'h0000_0044);
		send_branch(32'h0000_0040, 32'h0000_0044);
		set_mode(MODE_TAKEN);
		send_branch(32'h0000_0040, 32'h0000_0044);
		send_branch(32'h0000_0040, 32'h0000_0080);
		set_mode(MODE_NOT_TAKEN);
		send_branch(32'h0000_0040, 32'h0000_0044);
		send_branch(32'h0000_0040, 32'h0000_0080);

		for (int p = 0; p < PHASES; p++) begin
			set_mode(phase_mode[p]);
			run_random(PHASE_ITEMS, p != PHASES - 1);
		end
		start <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
